### src/sawrt_pkg.sv
package sawrt_pkg;

  // timeout register width and limits
  localparam int unsigned TIMEOUT_W = 20;
  localparam logic [TIMEOUT_W-1:0] MAX_ADAPTED_TIMEOUT = 20'd100000;
  localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT_REG     = 20'd1000000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET       = 20'd100000;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_TIMEOUT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADAPTIVE     = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_POLL = 2'd1,
    OP_ACK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PKT   = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

endpackage

### src/sawrt_adapt.sv
module sawrt_adapt
  import sawrt_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] now_us,
  input  logic [TIME_BITS-1:0] first_time,
  input  logic [TIMEOUT_W-1:0] cur_timeout,
  output logic [TIMEOUT_W-1:0] new_timeout
);

  logic [TIME_BITS-1:0] rtt;
  logic [TIME_BITS-1:0] avg;

  // halves summed separately, carry of the two low bits added back
  assign rtt = now_us - first_time;
  assign avg = {1'b0, rtt[TIME_BITS-1:1]}
             + TIME_BITS'({1'b0, cur_timeout[TIMEOUT_W-1:1]})
             + TIME_BITS'(rtt[0] & cur_timeout[0]);

  assign new_timeout = (avg > TIME_BITS'(MAX_ADAPTED_TIMEOUT)) ? MAX_ADAPTED_TIMEOUT
                                                              : avg[TIMEOUT_W-1:0];

endmodule

### src/stop_and_wait_retransmit_timer.sv
// channel  | dir | beat contents (low bit up)                         | handshake
// s_*      | in  | tuser: opcode; tdata: seq_num, now_us, zero pad     | s_tvalid/s_tready
// m_*      | out | tdata: retransmit, retransmit_seq, pending, status, | m_tvalid/m_tready
//          |     |        timeout_value, zero pad                      |
// cfg_*    | in  | cfg_index, cfg_data (register write)                | cfg_valid/cfg_ready
//
// one beat in, one beat out; a new beat is taken every cycle when the output drains
// each beat passes the input register, then the result register; slot state updates with
// the result register so the next beat already sees it
// reset clears the slot valid bit, both pipeline valids and adaptive mode, and sets the
// timeout to 100000 us; a stalled m_tready holds the result and backs up into s_tready
// cfg_ready is always high; writes are expected only while the block is idle
module stop_and_wait_retransmit_timer
  import sawrt_pkg::*;
#(
  parameter int SEQ_BITS  = 16,
  parameter int TIME_BITS = 32,
  localparam int IN_W  = ((SEQ_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int OUT_R = 1 + SEQ_BITS + 1 + 2 + TIMEOUT_W,
  localparam int OUT_W = ((OUT_R + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [1:0]             s_tuser,   // opcode
  input  logic [IN_W-1:0]        s_tdata,   // seq_num, now_us, zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // retransmit, retransmit_seq, pending,
                                            // status, timeout_value, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIMEOUT_W-1:0]   cfg_data
);

  // input register
  logic                 in_valid;
  logic [1:0]           in_op;
  logic [SEQ_BITS-1:0]  in_seq;
  logic [TIME_BITS-1:0] in_now;

  // slot and timer state
  logic                 slot_valid, slot_valid_next;
  logic [SEQ_BITS-1:0]  held_seq;
  logic [TIME_BITS-1:0] first_send_time;
  logic [TIME_BITS-1:0] last_send_time, last_send_time_next;
  logic [TIMEOUT_W-1:0] current_timeout, current_timeout_next;
  logic                 adaptive_enable;

  // result register
  logic                 out_valid;
  logic                 out_retransmit;
  logic [SEQ_BITS-1:0]  out_rt_seq;
  logic                 out_pending;
  status_t              out_status;
  logic [TIMEOUT_W-1:0] out_timeout;

  // combinational results
  logic                 advance;
  logic                 rt_next;
  logic [SEQ_BITS-1:0]  rt_seq_next;
  status_t              status_next;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIMEOUT_W-1:0] adapted_timeout;
  logic                 load_now;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_W'({out_timeout, out_status, out_pending, out_rt_seq,
                             out_retransmit});

  assign elapsed = in_now - last_send_time;

  sawrt_adapt #(
    .TIME_BITS(TIME_BITS)
  ) u_adapt (
    .now_us     (in_now),
    .first_time (first_send_time),
    .cur_timeout(current_timeout),
    .new_timeout(adapted_timeout)
  );

  // per-opcode next state and result
  always_comb begin
    slot_valid_next      = slot_valid;
    last_send_time_next  = last_send_time;
    current_timeout_next = current_timeout;
    rt_next              = 1'b0;
    rt_seq_next          = '0;
    status_next          = ST_OK;
    load_now             = 1'b0;
    unique case (op_t'(in_op))
      OP_LOAD: begin
        load_now            = 1'b1;
        slot_valid_next     = 1'b1;
        last_send_time_next = in_now;
      end
      OP_POLL: begin
        // strictly greater: a poll right at the timeout does not resend
        if (slot_valid && (elapsed > TIME_BITS'(current_timeout))) begin
          rt_next             = 1'b1;
          rt_seq_next         = held_seq;
          last_send_time_next = in_now;
        end
      end
      OP_ACK: begin
        if (!slot_valid) begin
          status_next = ST_NO_PKT;
        end else if (in_seq != held_seq) begin
          status_next = ST_MISMATCH;
        end else begin
          slot_valid_next = 1'b0;
          if (adaptive_enable) begin
            current_timeout_next = adapted_timeout;
          end
        end
      end
      default: begin
        // unused opcode: report state only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      slot_valid      <= 1'b0;
      current_timeout <= TIMEOUT_RESET;
      adaptive_enable <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        slot_valid      <= slot_valid_next;
        current_timeout <= current_timeout_next;
      end
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == CFG_INIT_TIMEOUT) begin
          // saturate the loaded timeout
          current_timeout <= (cfg_data > MAX_TIMEOUT_REG) ? MAX_TIMEOUT_REG : cfg_data;
        end else if (cfg_index == CFG_ADAPTIVE) begin
          adaptive_enable <= cfg_data[0];
        end else begin
          // index outside the register list: ignored
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= s_tuser;
      in_seq <= s_tdata[SEQ_BITS-1:0];
      in_now <= s_tdata[SEQ_BITS+TIME_BITS-1:SEQ_BITS];
    end
    if (advance) begin
      last_send_time <= last_send_time_next;
      if (load_now) begin
        held_seq        <= in_seq;
        first_send_time <= in_now;
      end
      out_retransmit <= rt_next;
      out_rt_seq     <= rt_seq_next;
      out_pending    <= slot_valid_next;
      out_status     <= status_next;
      out_timeout    <= current_timeout_next;
    end
  end

  // result pending flag mirrors the slot right after it is written
  a_pending_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_pending == slot_valid))
    else $error("pending flag disagrees with slot state");

  // a resend only comes from a held packet and never with an error
  a_rt_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_retransmit) |-> (out_status == ST_OK && out_pending))
    else $error("retransmit with error status or empty slot");

  // timeout never leaves its range
  a_timeout_range: assert property (@(posedge clk) disable iff (rst)
    current_timeout <= MAX_TIMEOUT_REG)
    else $error("timeout above limit");

  // an error acknowledgement leaves the slot as it was
  a_err_ack_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && status_next != ST_OK) |=> (slot_valid == $past(slot_valid)))
    else $error("error acknowledgement changed the slot");

  // a poll never changes the slot valid bit
  a_poll_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == OP_POLL) |=> $stable(slot_valid))
    else $error("poll changed the slot");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sawrt_pkg::*;

  // opcode value the block must treat as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IN_BITS  = 48;  // seq_num 16 + now_us 32
  localparam int OUT_BITS = 40;  // 1 + 16 + 1 + 2 + 20
  localparam int STALL_LIMIT = 1000;

  typedef enum {PACE_FULL, PACE_COIN, PACE_QUARTER, PACE_MOSTLY} pace_t;

  // one expected result beat
  typedef struct {
    logic                 resend;
    logic [15:0]          resend_seq;
    logic                 held;
    status_t              status;
    logic [TIMEOUT_W-1:0] timeout;
  } timer_verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [1:0]             s_tuser = OP_LOAD;   // opcode
  logic [IN_BITS-1:0]     s_tdata = '0;        // seq_num, now_us
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_BITS-1:0]    m_tdata;             // retransmit, retransmit_seq, pending,
                                               // status, timeout_value
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_INIT_TIMEOUT;
  logic [TIMEOUT_W-1:0]   cfg_data = '0;

  stop_and_wait_retransmit_timer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the timer state
  logic                 slot_full   = 1'b0;
  logic [15:0]          slot_seq    = '0;
  logic [31:0]          first_stamp = '0;
  logic [31:0]          last_stamp  = '0;
  logic [TIMEOUT_W-1:0] rto_us      = TIMEOUT_RESET;
  logic                 adapt_on    = 1'b0;

  timer_verdict_t verdict_q[$];

  int fail_count  = 0;
  int beats_in    = 0;
  int beats_out   = 0;
  int resends     = 0;
  int bad_acks    = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  // current stimulus time base
  logic [31:0] t_now = '0;

  // next state and result for one event
  function automatic timer_verdict_t timer_step(logic [1:0] op, logic [15:0] seq,
                                                logic [31:0] now);
    timer_verdict_t v;
    logic [31:0] span;
    logic [32:0] mean;
    v.resend     = 1'b0;
    v.resend_seq = '0;
    v.status     = ST_OK;
    case (op)
      OP_LOAD: begin
        slot_full   = 1'b1;
        slot_seq    = seq;
        first_stamp = now;
        last_stamp  = now;
      end
      OP_POLL: begin
        if (slot_full) begin
          span = now - last_stamp;   // wraps modulo 2^32
          // strictly greater: a poll right at the timeout does not resend
          if (span > 32'(rto_us)) begin
            v.resend     = 1'b1;
            v.resend_seq = slot_seq;
            last_stamp   = now;
          end
        end
      end
      OP_ACK: begin
        if (!slot_full) begin
          v.status = ST_NO_PKT;
        end else if (seq != slot_seq) begin
          v.status = ST_MISMATCH;
        end else begin
          if (adapt_on) begin
            span = now - first_stamp;
            // halve both before adding, round up only when both are odd
            mean = 33'(span >> 1) + 33'(rto_us >> 1) + 33'(span[0] & rto_us[0]);
            rto_us = (mean > 33'(MAX_ADAPTED_TIMEOUT)) ? MAX_ADAPTED_TIMEOUT : mean[19:0];
          end
          slot_full = 1'b0;
        end
      end
      default: ;  // unused opcode leaves everything alone
    endcase
    v.held    = slot_full;
    v.timeout = rto_us;
    return v;
  endfunction

  // one event beat, with sender bursts and random gaps between them
  task automatic send_event(logic [1:0] op, logic [15:0] seq, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, seq};
    do @(posedge clk); while (!s_tready);
    verdict_q.push_back(timer_step(op, seq, now));
    beats_in++;
  endtask

  // register write, only once the pipeline has drained
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [TIMEOUT_W-1:0] val);
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);   // two-stage pipeline, plus margin
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_INIT_TIMEOUT) begin
      // values above the register limit saturate
      rto_us = (val > MAX_TIMEOUT_REG) ? MAX_TIMEOUT_REG : val;
    end else if (idx == CFG_ADAPTIVE) begin
      adapt_on = val[0];
    end
    cfg_writes++;
  endtask

  // reset values, empty slot cases, unused opcode, default timeout edge
  task automatic test_reset_defaults();
    send_event(OP_ACK, 16'h0000, 32'd0);          // ack with nothing held
    send_event(OP_POLL, 16'h0000, 32'd0);         // poll with nothing held
    send_event(OP_UNUSED, 16'hffff, 32'hffffffff);
    send_event(OP_LOAD, 16'h0000, 32'd0);
    send_event(OP_POLL, 16'h0000, 32'd100000);    // exactly at timeout: no resend
    send_event(OP_POLL, 16'h0000, 32'd100001);
    send_event(OP_ACK, 16'h0001, 32'd100002);     // wrong number
    send_event(OP_ACK, 16'h0000, 32'd100003);
  endtask

  // timeout register extremes, saturation and time wrap
  task automatic test_timeout_limits();
    write_reg(CFG_INIT_TIMEOUT, 20'd0);
    send_event(OP_LOAD, 16'hffff, 32'hffffffff);
    send_event(OP_POLL, 16'h0000, 32'hffffffff);  // zero elapsed, zero timeout
    send_event(OP_POLL, 16'h0000, 32'h00000000);  // one elapsed across the wrap
    write_reg(CFG_INIT_TIMEOUT, 20'hfffff);       // saturates to the register limit
    send_event(OP_LOAD, 16'h1234, 32'd5);         // overwrites the held packet
    send_event(OP_POLL, 16'h1234, 32'd1000005);
    send_event(OP_POLL, 16'h1234, 32'd1000006);
    write_reg(CFG_INIT_TIMEOUT, 20'd511);
    send_event(OP_LOAD, 16'h8001, 32'hffffff00);
    send_event(OP_POLL, 16'h8001, 32'h00000100);  // 512 elapsed through the wrap
    send_event(OP_ACK, 16'h8001, 32'h00000101);
  endtask

  // adaptive timeout: rounding and upper clamp
  task automatic test_adaptive();
    write_reg(CFG_ADAPTIVE, 20'd1);
    write_reg(CFG_INIT_TIMEOUT, 20'd7);
    send_event(OP_LOAD, 16'h0005, 32'd100);
    send_event(OP_ACK, 16'h0005, 32'd103);        // both odd: rounds up
    send_event(OP_LOAD, 16'h7fff, 32'h80000000);
    send_event(OP_ACK, 16'h7fff, 32'h7fffffff);   // huge round trip clamps
    write_reg(CFG_ADAPTIVE, 20'd0);
  endtask

  // load, a few polls around the timeout, then usually a matching ack
  task automatic run_session();
    logic [15:0] seq;
    int polls;
    int pick;
    seq = 16'($urandom);
    if ($urandom_range(0, 5) == 0) t_now = $urandom;
    send_event(OP_LOAD, seq, t_now);
    polls = $urandom_range(0, 4);
    repeat (polls) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: t_now = last_stamp + 32'(rto_us);
        1: t_now = last_stamp + 32'(rto_us) + 32'd1;
        default: t_now = t_now + 32'($urandom_range(0, int'(rto_us) + int'(rto_us) / 2 + 2));
      endcase
      send_event(OP_POLL, 16'($urandom), t_now);
      // noise: any opcode, any number, any time
      if ($urandom_range(0, 7) == 0)
        send_event(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
    end
    t_now = t_now + 32'($urandom_range(0, int'(rto_us) + 2));
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      send_event(OP_ACK, seq, t_now);
      if ($urandom_range(0, 4) == 0) send_event(OP_ACK, seq, t_now + 32'd1);
    end else if (pick == 8) begin
      send_event(OP_ACK, seq ^ 16'($urandom_range(1, 65535)), t_now);
    end
  endtask

  // random sessions over several timeout and adaptive settings
  task automatic test_random_sessions();
    logic [TIMEOUT_W-1:0] rto_pick[6];
    int stop_at;
    rto_pick[0] = 20'd0;
    rto_pick[1] = 20'd37;
    rto_pick[2] = 20'($urandom_range(100, 5000));
    rto_pick[3] = MAX_TIMEOUT_REG;
    rto_pick[4] = 20'hfffff;
    rto_pick[5] = 20'($urandom_range(0, 2000));
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_INIT_TIMEOUT, rto_pick[p]);
      write_reg(CFG_ADAPTIVE, 20'(p % 2));
      stop_at = beats_in + 105;
      while (beats_in < stop_at) run_session();
    end
  endtask

  // result checker: every output beat against the oldest expectation
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    timer_verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (m_tdata[0]) resends++;
      if (m_tdata[19:18] != ST_OK) bad_acks++;
      if (verdict_q.size() == 0) begin
        $display("%0t ns: result beat with none expected, got %0h", $time, m_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("retransmit", 32'(want.resend), 32'(m_tdata[0]));
        check_field("retransmit_seq", 32'(want.resend_seq), 32'(m_tdata[16:1]));
        check_field("pending", 32'(want.held), 32'(m_tdata[17]));
        check_field("status", 32'(want.status), 32'(m_tdata[19:18]));
        check_field("timeout_value", 32'(want.timeout), 32'(m_tdata[39:20]));
      end
    end
  end

  // receiver back-pressure, pattern picked anew whenever the low six bits of pace_count are zero
  pace_t      pace_mode  = PACE_FULL;
  logic [7:0] pace_count = '0;

  always @(posedge clk) begin
    pace_count <= pace_count + 8'd1;
    if (pace_count[5:0] == 6'd0) pace_mode <= pace_t'($urandom_range(0, 3));
    case (pace_mode)
      PACE_FULL:    m_tready <= 1'b1;
      PACE_COIN:    m_tready <= 1'($urandom_range(0, 1));
      PACE_QUARTER: m_tready <= (pace_count[1:0] == 2'd0);
      default:      m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // watchdog: too long with no beat moving anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_timeout_limits();
    test_adaptive();
    test_random_sessions();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // catch any stray beat after the last one
    $display("covered %0d event beats, %0d result beats, %0d resends, %0d rejected acks",
             beats_in, beats_out, resends, bad_acks);
    $display("%0d register writes across timeout extremes and both adaptive modes",
             cfg_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### stop_and_wait_retransmit_timer.f
src/sawrt_pkg.sv
src/sawrt_adapt.sv
src/stop_and_wait_retransmit_timer.sv
tb/sv/tb_top.sv
